[rtl/clsr_pkg.sv]
// Shared types and constants for the combined LCG shuffle generator.
// Used by every module under rtl except clsr_ram; no dependencies.
package clsr_pkg;

    localparam int          VALUE_W         = 31;
    localparam int unsigned TABLE_DEPTH_DEF = 32;
    localparam int unsigned WARMUP_EXTRA    = 8;

    localparam logic [31:0] MOD_A     = 32'd2147483563;
    localparam logic [31:0] MOD_B     = 32'd2147483399;
    localparam logic [15:0] MUL_A     = 16'd40014;
    localparam logic [15:0] MUL_B     = 16'd40692;
    // 2^31 folded back modulo each modulus
    localparam logic [7:0]  FOLD_A    = 8'd85;
    localparam logic [7:0]  FOLD_B    = 8'd249;
    localparam logic [30:0] GEN_A_INIT = 31'd1;
    localparam logic [30:0] GEN_B_INIT = 31'd123456789;
    localparam logic [30:0] OUT_SPAN   = 31'd2147483562;

    localparam logic MODE_DRAW   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic {
        GEN_A = 1'b0,
        GEN_B = 1'b1
    } gen_sel_t;

    typedef struct packed {
        logic     start;
        gen_sel_t sel;
        value_t   operand;
    } mul_req_t;

    typedef struct packed {
        logic   done;
        value_t result;
    } mul_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED_GO,
        ST_SEED_WAIT,
        ST_DRAW_A_GO,
        ST_DRAW_A_WAIT,
        ST_DRAW_B_GO,
        ST_DRAW_B_WAIT,
        ST_INDEX_GO,
        ST_INDEX_WAIT,
        ST_READ,
        ST_EMIT
    } clsr_state_t;

endpackage

[rtl/combined_lcg_shuffle_rng.sv]
// Top level: sequencer, generator state, shuffle table and output register.
// Depends on clsr_pkg, clsr_ram, clsr_modmul and clsr_binidx.
// A draw makes two passes through the three-stage modular multiplier, then one through the
// two-stage index unit, before m_tvalid; a reseed first runs TABLE_DEPTH + 8 multiplier
// passes to fill the table.
// Requests do not overlap: s_tready is high only while idle and rises with m_tvalid.
// Reset: synchronous; then every table entry is cleared to zero with s_tready low.
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] random_value
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + WARMUP_EXTRA);

    clsr_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    value_t            gen_a_reg, gen_a_next;
    value_t            gen_b_reg, gen_b_next;
    value_t            last_reg, last_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    value_t            out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    mul_req_t          mul_req;
    mul_rsp_t          mul_rsp;
    logic              div_start, div_done;
    logic [ADDR_W-1:0] div_idx;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    value_t            ram_wdata, ram_rdata;

    logic              s_fire, out_free, emit;
    value_t            seed;
    logic [31:0]       diff;
    value_t            draw_value;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign seed     = (s_tdata[30:0] == '0) ? 31'd1 : s_tdata[30:0];
    assign diff     = {1'b0, ram_rdata} - {1'b0, gen_b_reg};
    assign draw_value = (diff[31] || diff == '0) ? 31'(diff + {1'b0, OUT_SPAN})
                                                 : diff[30:0];

    clsr_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    clsr_binidx #(.DEPTH(TABLE_DEPTH)) u_binidx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .value   (last_reg),
        .done    (div_done),
        .idx     (div_idx)
    );

    clsr_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:       if (cnt_reg == '0) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser[0] == MODE_RESEED) ? ST_SEED_GO : ST_DRAW_A_GO;
                end
            end
            ST_SEED_GO:     state_next = ST_SEED_WAIT;
            ST_SEED_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = (cnt_reg == '0) ? ST_DRAW_A_GO : ST_SEED_GO;
                end
            end
            ST_DRAW_A_GO:   state_next = ST_DRAW_A_WAIT;
            ST_DRAW_A_WAIT: if (mul_rsp.done) state_next = ST_DRAW_B_GO;
            ST_DRAW_B_GO:   state_next = ST_DRAW_B_WAIT;
            ST_DRAW_B_WAIT: if (mul_rsp.done) state_next = ST_INDEX_GO;
            ST_INDEX_GO:    state_next = ST_INDEX_WAIT;
            ST_INDEX_WAIT:  if (div_done) state_next = ST_READ;
            ST_READ:        state_next = ST_EMIT;
            ST_EMIT:        if (out_free) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        mul_req.start   = 1'b0;
        mul_req.sel     = GEN_A;
        mul_req.operand = gen_a_reg;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[ADDR_W-1:0];
        ram_wdata       = '0;
        emit            = 1'b0;
        unique case (state_reg)
            ST_CLEAR:       ram_we = 1'b1;
            ST_IDLE:        s_tready = 1'b1;
            ST_SEED_GO,
            ST_DRAW_A_GO:   mul_req.start = 1'b1;
            ST_SEED_WAIT: begin
                ram_we    = mul_rsp.done && (cnt_reg < CNT_W'(TABLE_DEPTH));
                ram_wdata = mul_rsp.result;
            end
            ST_DRAW_B_GO: begin
                mul_req.start   = 1'b1;
                mul_req.sel     = GEN_B;
                mul_req.operand = gen_b_reg;
            end
            ST_INDEX_GO:    div_start = 1'b1;
            ST_EMIT: begin
                emit      = out_free;
                ram_we    = out_free;
                ram_waddr = idx_reg;
                ram_wdata = gen_a_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt_next      = cnt_reg;
        gen_a_next    = gen_a_reg;
        gen_b_next    = gen_b_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:       cnt_next = cnt_reg - 1'b1;
            ST_IDLE: begin
                if (s_fire && s_tuser[0] == MODE_RESEED) begin
                    gen_a_next = seed;
                    gen_b_next = seed;
                    cnt_next   = CNT_W'(TABLE_DEPTH + WARMUP_EXTRA - 1);
                end
            end
            ST_SEED_WAIT: begin
                if (mul_rsp.done) begin
                    gen_a_next = mul_rsp.result;
                    cnt_next   = cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        last_next = mul_rsp.result;
                    end
                end
            end
            ST_DRAW_A_WAIT: if (mul_rsp.done) gen_a_next = mul_rsp.result;
            ST_DRAW_B_WAIT: if (mul_rsp.done) gen_b_next = mul_rsp.result;
            ST_INDEX_WAIT:  if (div_done) idx_next = div_idx;
            ST_EMIT: begin
                if (emit) begin
                    last_next     = draw_value;
                    out_next      = draw_value;
                    m_tvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        out_reg <= out_next;
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= CNT_W'(TABLE_DEPTH - 1);
            gen_a_reg    <= GEN_A_INIT;
            gen_b_reg    <= GEN_B_INIT;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            gen_a_reg    <= gen_a_next;
            gen_b_reg    <= gen_b_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg};

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_reg != '0 && out_reg <= OUT_SPAN))
        else $error("result outside 1..OUT_SPAN");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_SEED_WAIT || state_reg == ST_DRAW_A_WAIT ||
                          state_reg == ST_DRAW_B_WAIT))
        else $error("multiplier result arrived outside a wait state");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_INDEX_WAIT && div_idx <= ADDR_W'(TABLE_DEPTH - 1)))
        else $error("index result unexpected or out of table range");

endmodule

[rtl/clsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/clsr_modmul.sv]
// Shared three-stage unit: operand times multiplier modulo either modulus.
// Depends on clsr_pkg.
module clsr_modmul
    import clsr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [46:0] prod_reg;
    logic [31:0] fold_reg;
    value_t      res_reg;
    gen_sel_t    sel1_reg, sel2_reg;
    logic        v1_reg, v2_reg, v3_reg;

    logic [15:0] mul_c;
    logic [7:0]  fold_c;
    logic [31:0] mod_c;
    logic [46:0] prod_next;
    logic [23:0] hi_mul;
    logic [31:0] fold_next;
    value_t      res_next;

    always_comb begin
        mul_c     = (req.sel == GEN_B) ? MUL_B : MUL_A;
        prod_next = {16'b0, req.operand} * {31'b0, mul_c};
        fold_c    = (sel1_reg == GEN_B) ? FOLD_B : FOLD_A;
        hi_mul    = {8'b0, prod_reg[46:31]} * {16'b0, fold_c};
        fold_next = {8'b0, hi_mul} + {1'b0, prod_reg[30:0]};
        mod_c     = (sel2_reg == GEN_B) ? MOD_B : MOD_A;
        res_next  = (fold_reg >= mod_c) ? 31'(fold_reg - mod_c) : fold_reg[30:0];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        sel1_reg <= req.sel;
        fold_reg <= fold_next;
        sel2_reg <= sel1_reg;
        res_reg  <= res_next;
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign rsp.done   = v3_reg;
    assign rsp.result = res_reg;

endmodule

[rtl/clsr_binidx.sv]
// Shuffle table index: the last output divided by the bin width, saturated to the table size.
// Reciprocal multiply, then one correction step, each registered. Depends on clsr_pkg.
module clsr_binidx
    import clsr_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  value_t            value,
    output logic              done,
    output logic [ADDR_W-1:0] idx
);

    localparam int          RECIP_W   = ADDR_W + 1;
    localparam int          PROD_W    = VALUE_W + RECIP_W;
    localparam logic [31:0] BIN_W     = 32'(1 + OUT_SPAN / DEPTH);
    localparam logic [32:0] SAT_LIMIT = 33'(BIN_W) * 33'(DEPTH);
    // floor(2^31 / BIN_W): the estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 31) / 64'(BIN_W));

    value_t              val_reg, val_next;
    logic [ADDR_W-1:0]   qe_reg, qe_next;
    logic                sat_reg, sat_next;
    logic [ADDR_W-1:0]   q_reg, q_next;
    logic                run_reg;
    logic                done_reg;
    logic [PROD_W-1:0]   prod;
    logic [31:0]         back;
    logic [31:0]         rem;
    logic                bump;

    always_comb begin
        prod     = PROD_W'(value) * PROD_W'(RECIP);
        val_next = value;
        qe_next  = prod[VALUE_W +: ADDR_W];
        sat_next = ({2'b0, value} >= SAT_LIMIT);
        back     = 32'(qe_reg) * BIN_W;
        rem      = {1'b0, val_reg} - back;
        bump     = (rem >= BIN_W);
        q_next   = sat_reg ? ADDR_W'(DEPTH - 1) : qe_reg + ADDR_W'(bump);
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        qe_reg  <= qe_next;
        sat_reg <= sat_next;
        q_reg   <= q_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= start;
            done_reg <= run_reg;
        end
    end

    assign done = done_reg;
    assign idx  = q_reg;

endmodule

[tb/combined_lcg_shuffle_rng_chk.sv]
`timescale 1ns / 100ps
// Checker for combined_lcg_shuffle_rng: watches both stream channels, predicts each
// random value from the accepted requests and compares it with the result channel.
// Depends on clsr_pkg; instantiated by combined_lcg_shuffle_rng_tb.
module combined_lcg_shuffle_rng_chk
    import clsr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [30:0] random_value
    output int          fail_count,
    output int          pending
);

    localparam longint unsigned BIN_WIDTH = 1 + longint'(OUT_SPAN) / TABLE_DEPTH;

    value_t      gen_a;
    value_t      gen_b;
    value_t      last_value;
    value_t      shuffle_tbl [TABLE_DEPTH];
    value_t      expected_values [$];
    value_t      want;
    int unsigned result_num;

    function automatic value_t mul_mod(input value_t x, input longint unsigned mul,
                                       input longint unsigned modulus);
        longint unsigned prod;
        prod = x;
        prod = (prod * mul) % modulus;
        return prod[30:0];
    endfunction

    task automatic reset_generators();
        gen_a      = GEN_A_INIT;
        gen_b      = GEN_B_INIT;
        last_value = '0;
        foreach (shuffle_tbl[i])
            shuffle_tbl[i] = '0;
        expected_values.delete();
    endtask

    function automatic value_t draw_value(input logic mode, input value_t seed);
        value_t      start_val;
        int unsigned idx;
        longint      diff;
        if (mode == MODE_RESEED) begin
            start_val = (seed == '0) ? value_t'(1) : seed;
            gen_a = start_val;
            gen_b = start_val;
            for (int n = TABLE_DEPTH + WARMUP_EXTRA - 1; n >= 0; n--) begin
                gen_a = mul_mod(gen_a, MUL_A, MOD_A);
                if (n < TABLE_DEPTH)
                    shuffle_tbl[n] = gen_a;
            end
            last_value = shuffle_tbl[0];
        end
        gen_a = mul_mod(gen_a, MUL_A, MOD_A);
        gen_b = mul_mod(gen_b, MUL_B, MOD_B);
        idx = last_value / BIN_WIDTH;
        if (idx >= TABLE_DEPTH)
            idx = TABLE_DEPTH - 1;
        diff = longint'(shuffle_tbl[idx]) - longint'(gen_b);
        shuffle_tbl[idx] = gen_a;
        if (diff < 1)
            diff = diff + longint'(OUT_SPAN);
        last_value = diff[30:0];
        return last_value;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_generators();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("result %0d: random_value 0x%08h with no request waiting",
                                              result_num, m_tdata[30:0]));
                end else begin
                    want = expected_values.pop_front();
                    if (m_tdata[30:0] !== want)
                        report_mismatch($sformatf("result %0d: random_value 0x%08h, want 0x%08h",
                                                  result_num, m_tdata[30:0], want));
                end
                result_num++;
            end
            if (s_tvalid && s_tready) begin
                expected_values.push_back(draw_value(s_tuser[0], s_tdata[30:0]));
            end
        end
        pending = expected_values.size();
    end

endmodule

[tb/combined_lcg_shuffle_rng_tb.sv]
`timescale 1ns / 100ps
// Testbench top for combined_lcg_shuffle_rng: drives draw and reseed requests in bursts,
// stalls the result channel, and reports the verdict from combined_lcg_shuffle_rng_chk.
// Depends on clsr_pkg, the block under rtl and the checker module.
module combined_lcg_shuffle_rng_tb
    import clsr_pkg::*;
();

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HOLD
    } rx_style_t;

    localparam int     TOTAL_REQUESTS = 900;
    localparam int     DRAIN_CYCLES   = 40;
    localparam value_t SEED_TOP       = 31'h7FFF_FFFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          issued     = 0;
    rx_style_t   rx_style   = RX_OPEN;
    int          rx_left    = 0;
    int unsigned rx_phase   = 0;

    always #1 aclk = ~aclk;

    combined_lcg_shuffle_rng dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    combined_lcg_shuffle_rng_chk chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_left  = $urandom_range(8, 64);
        end
        rx_left--;
        rx_phase++;
        case (rx_style)
            RX_OPEN:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_tready <= ((rx_phase % 4) == 0);
            default:     m_tready <= 1'b0;
        endcase
    end

    task automatic send_request(input logic mode, input value_t seed);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 24);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= {1'b0, value_t'($urandom())};
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, seed};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        issued++;
    endtask

    initial begin
        value_t seed;
        int     run_len;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // draw from the reset state, before any reseed
        repeat (3) send_request(MODE_DRAW, value_t'($urandom()));
        send_request(MODE_RESEED, '0);
        send_request(MODE_DRAW, SEED_TOP);
        send_request(MODE_RESEED, 31'd1);
        send_request(MODE_RESEED, OUT_SPAN);
        // seed equal to the first modulus pins the first generator at zero
        send_request(MODE_RESEED, value_t'(MOD_A));
        repeat (3) send_request(MODE_DRAW, '0);
        send_request(MODE_RESEED, SEED_TOP);
        send_request(MODE_RESEED, value_t'(MOD_B));
        send_request(MODE_RESEED, 31'h5555_5555);
        send_request(MODE_RESEED, 31'h2AAA_AAAA);
        repeat (4) send_request(MODE_DRAW, value_t'($urandom()));

        while (issued < TOTAL_REQUESTS) begin
            case ($urandom_range(0, 19))
                0:       seed = '0;
                1:       seed = value_t'(MOD_A);
                2:       seed = SEED_TOP;
                3:       seed = OUT_SPAN;
                default: seed = value_t'($urandom());
            endcase
            if ($urandom_range(0, 9) != 0)
                send_request(MODE_RESEED, seed);
            run_len = $urandom_range(4, 48);
            repeat (run_len) send_request(MODE_DRAW, value_t'($urandom()));
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("combined_lcg_shuffle_rng_tb: PASS");
        else
            $display("combined_lcg_shuffle_rng_tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("combined_lcg_shuffle_rng_tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/clsr_pkg.sv
rtl/clsr_ram.sv
rtl/clsr_modmul.sv
rtl/clsr_binidx.sv
rtl/combined_lcg_shuffle_rng.sv
tb/combined_lcg_shuffle_rng_chk.sv
tb/combined_lcg_shuffle_rng_tb.sv
